// File: rtl/m2u_pkg.sv
// m2u_pkg: constants, codes and the event packet type for the MIDI to USB event packetiser.
// No dependencies; imported by the top level.
package m2u_pkg;

	// MIDI status bytes that need special handling
	localparam logic [7:0] ST_SYSEX_START = 8'hF0;
	localparam logic [7:0] ST_MTC_QFRAME  = 8'hF1;
	localparam logic [7:0] ST_SONG_POS    = 8'hF2;
	localparam logic [7:0] ST_SONG_SEL    = 8'hF3;
	localparam logic [7:0] ST_UNDEF_F5    = 8'hF5;
	localparam logic [7:0] ST_TUNE_REQ    = 8'hF6;
	localparam logic [7:0] ST_SYSEX_END   = 8'hF7;
	localparam logic [7:0] ST_REALTIME    = 8'hF8;
	localparam logic [7:0] ST_NONE        = 8'h00;

	// Code index numbers
	localparam logic [3:0] CIN_NONE       = 4'h0;
	localparam logic [3:0] CIN_SYS2       = 4'h2;
	localparam logic [3:0] CIN_SYS3       = 4'h3;
	localparam logic [3:0] CIN_SYSEX_CONT = 4'h4;
	localparam logic [3:0] CIN_END1       = 4'h5;
	localparam logic [3:0] CIN_END2       = 4'h6;
	localparam logic [3:0] CIN_END3       = 4'h7;
	localparam logic [3:0] CIN_REALTIME   = 4'hF;

	// Upper nibbles of channel message status bytes
	localparam logic [3:0] KIND_NOTE_OFF  = 4'h8;
	localparam logic [3:0] KIND_CTRL      = 4'hB;
	localparam logic [3:0] KIND_PROG      = 4'hC;
	localparam logic [3:0] KIND_CHAN_PRES = 4'hD;
	localparam logic [3:0] KIND_PITCH     = 4'hE;
	localparam logic [3:0] KIND_SYSTEM    = 4'hF;

	// One event packet
	typedef struct packed {
		logic [3:0] code_index;
		logic [7:0] msg_byte0;
		logic [7:0] msg_byte1;
		logic [7:0] msg_byte2;
		logic       last_of_run;
	} evt_pkt_t;

	// Packet count for one input byte (0, 1 or 2)
	typedef logic [1:0] pkt_cnt_t;

endpackage

// File: rtl/m2u_midi_if.sv
// m2u_midi_if: valid/ready channel carrying one raw MIDI byte per item.
// No dependencies.
interface m2u_midi_if;
	logic       valid;
	logic       ready;
	logic [7:0] midi_byte;

	modport source (output valid, output midi_byte, input ready);
	modport sink (input valid, input midi_byte, output ready);
endinterface

// File: rtl/m2u_evt_if.sv
// m2u_evt_if: valid/ready channel carrying one USB-MIDI style event packet per item.
// No dependencies.
interface m2u_evt_if;
	logic       valid;
	logic       ready;
	logic [3:0] code_index;
	logic [7:0] msg_byte0;
	logic [7:0] msg_byte1;
	logic [7:0] msg_byte2;
	logic       last_of_run;

	modport source (output valid, output code_index, output msg_byte0, output msg_byte1,
		output msg_byte2, output last_of_run, input ready);
	modport sink (input valid, input code_index, input msg_byte0, input msg_byte1,
		input msg_byte2, input last_of_run, output ready);
endinterface

// File: rtl/midi_to_usb_event_packetizer_unit.sv
// midi_to_usb_event_packetizer_unit: raw MIDI bytes in, USB-MIDI style event packets out.
// Depends on m2u_pkg, m2u_midi_if and m2u_evt_if.
//
//   channel   dir   item                                   handshake
//   midi_in   in    midi_byte                              valid/ready
//   evt_out   out   code_index, msg_byte0..2, last_of_run  valid/ready
//
// Each byte is decoded in the cycle it is taken; its packets (none, one or two) land in a
// two-entry result register and leave one per cycle while evt_out is ready. A byte is taken
// whenever the result register is empty or its last packet leaves in the same cycle, so one
// byte per cycle is sustained while each byte gives at most one packet and evt_out is ready;
// a byte giving two stalls input. Reset clears running status, held bytes, result register.
module midi_to_usb_event_packetizer_unit
	import m2u_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	m2u_midi_if.sink      midi_in,
	m2u_evt_if.source     evt_out
);

	// Encoder state
	logic [7:0] run_status_q;
	logic       fh_valid_q;
	logic [6:0] fh_byte_q;
	logic       sh_valid_q;
	logic [6:0] sh_byte_q;
	logic       sx_sent_q;

	// Result register
	evt_pkt_t   pkt0_q;
	evt_pkt_t   pkt1_q;
	pkt_cnt_t   cnt_q;

	// Next-state values and new packets
	logic [7:0] n_status;
	logic       n_fh_valid;
	logic [6:0] n_fh_byte;
	logic       n_sh_valid;
	logic [6:0] n_sh_byte;
	logic       n_sx_sent;
	evt_pkt_t   new0;
	evt_pkt_t   new1;
	pkt_cnt_t   new_cnt;

	logic       in_fire;
	logic       out_fire;

	// Closing packet of a system-exclusive message
	function automatic evt_pkt_t sysex_end_pkt(input logic sent, input logic fhv,
		input logic shv, input logic [6:0] fhb, input logic [6:0] shb);
		evt_pkt_t p;
		p.last_of_run = 1'b0;
		if (sent) begin
			if (shv) begin
				p.code_index = CIN_END3;
				p.msg_byte0  = {1'b0, fhb};
				p.msg_byte1  = {1'b0, shb};
				p.msg_byte2  = ST_SYSEX_END;
			end else if (fhv) begin
				p.code_index = CIN_END2;
				p.msg_byte0  = {1'b0, fhb};
				p.msg_byte1  = ST_SYSEX_END;
				p.msg_byte2  = 8'h00;
			end else begin
				p.code_index = CIN_END1;
				p.msg_byte0  = ST_SYSEX_END;
				p.msg_byte1  = 8'h00;
				p.msg_byte2  = 8'h00;
			end
		end else if (fhv) begin
			p.code_index = CIN_END3;
			p.msg_byte0  = ST_SYSEX_START;
			p.msg_byte1  = {1'b0, fhb};
			p.msg_byte2  = ST_SYSEX_END;
		end else begin
			p.code_index = CIN_END2;
			p.msg_byte0  = ST_SYSEX_START;
			p.msg_byte1  = ST_SYSEX_END;
			p.msg_byte2  = 8'h00;
		end
		return p;
	endfunction

	function automatic evt_pkt_t mk_pkt(input logic [3:0] cin, input logic [7:0] b0,
		input logic [7:0] b1, input logic [7:0] b2);
		evt_pkt_t p;
		p.code_index  = cin;
		p.msg_byte0   = b0;
		p.msg_byte1   = b1;
		p.msg_byte2   = b2;
		p.last_of_run = 1'b0;
		return p;
	endfunction

	// Handshakes
	assign out_fire       = evt_out.valid & evt_out.ready;
	assign midi_in.ready  = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && evt_out.ready);
	assign in_fire        = midi_in.valid & midi_in.ready;

	// Decode one byte against the current state
	always_comb begin
		logic [7:0] c;
		logic [3:0] kind;
		logic       emit;
		evt_pkt_t   pkt;
		c          = midi_in.midi_byte;
		kind       = run_status_q[7:4];
		emit       = 1'b0;
		pkt        = mk_pkt(CIN_NONE, 8'h00, 8'h00, 8'h00);
		n_status   = run_status_q;
		n_fh_valid = fh_valid_q;
		n_fh_byte  = fh_byte_q;
		n_sh_valid = sh_valid_q;
		n_sh_byte  = sh_byte_q;
		n_sx_sent  = sx_sent_q;
		new0       = mk_pkt(CIN_NONE, 8'h00, 8'h00, 8'h00);
		new1       = mk_pkt(CIN_NONE, 8'h00, 8'h00, 8'h00);
		new_cnt    = 2'd0;

		// A status byte other than end-of-sysex closes an open sysex first
		if (c[7] && (run_status_q == ST_SYSEX_START) && (c != ST_SYSEX_END)) begin
			new0       = sysex_end_pkt(sx_sent_q, fh_valid_q, sh_valid_q, fh_byte_q, sh_byte_q);
			new_cnt    = 2'd1;
			n_status   = ST_NONE;
			n_fh_valid = 1'b0;
			n_sh_valid = 1'b0;
			n_sx_sent  = 1'b1;
		end

		if (c[7]) begin
			// Status bytes
			if (c < ST_TUNE_REQ) begin
				n_status   = c;
				n_fh_valid = 1'b0;
				n_sx_sent  = 1'b0;
			end else if ((c == ST_SYSEX_END) && (n_status == ST_SYSEX_START)) begin
				emit     = 1'b1;
				pkt      = sysex_end_pkt(n_sx_sent, n_fh_valid, n_sh_valid, n_fh_byte,
					n_sh_byte);
				n_status = ST_NONE;
			end else if (c < ST_REALTIME) begin
				emit     = 1'b1;
				pkt      = mk_pkt(CIN_END1, c, 8'h00, 8'h00);
				n_status = ST_NONE;
			end else begin
				// real-time: no state change
				pkt = mk_pkt(CIN_REALTIME, c, 8'h00, 8'h00);
			end
		end else begin
			// Data bytes, interpreted by running status
			case (kind) inside
				KIND_PROG, KIND_CHAN_PRES: begin
					emit = 1'b1;
					pkt  = mk_pkt(kind, run_status_q, c, 8'h00);
				end
				[KIND_NOTE_OFF:KIND_CTRL], KIND_PITCH: begin
					if (fh_valid_q) begin
						emit = 1'b1;
						pkt  = mk_pkt(kind, run_status_q, {1'b0, fh_byte_q}, c);
					end else begin
						n_fh_byte  = c[6:0];
						n_fh_valid = 1'b1;
					end
				end
				KIND_SYSTEM: begin
					case (run_status_q) inside
						ST_SYSEX_START: begin
							if (sx_sent_q) begin
								if (sh_valid_q) begin
									emit = 1'b1;
									pkt  = mk_pkt(CIN_SYSEX_CONT, {1'b0, fh_byte_q},
										{1'b0, sh_byte_q}, c);
								end else if (fh_valid_q) begin
									n_sh_byte  = c[6:0];
									n_sh_valid = 1'b1;
								end else begin
									n_fh_byte  = c[6:0];
									n_fh_valid = 1'b1;
								end
							end else if (fh_valid_q) begin
								emit = 1'b1;
								pkt  = mk_pkt(CIN_SYSEX_CONT, ST_SYSEX_START,
									{1'b0, fh_byte_q}, c);
							end else begin
								n_fh_byte  = c[6:0];
								n_fh_valid = 1'b1;
							end
						end
						ST_MTC_QFRAME, ST_SONG_SEL, ST_UNDEF_F5: begin
							emit = 1'b1;
							pkt  = mk_pkt(CIN_SYS2, run_status_q, c, 8'h00);
						end
						ST_SONG_POS: begin
							if (fh_valid_q) begin
								emit = 1'b1;
								pkt  = mk_pkt(CIN_SYS3, run_status_q, {1'b0, fh_byte_q}, c);
							end else begin
								n_fh_byte  = c[6:0];
								n_fh_valid = 1'b1;
							end
						end
						default: begin
						end
					endcase
				end
				default: begin
					// no running status: byte dropped
				end
			endcase
		end

		// Packets that go through the normal emit path clear held bytes
		if (emit) begin
			n_fh_valid = 1'b0;
			n_sh_valid = 1'b0;
			n_sx_sent  = 1'b1;
		end

		// Place the packet behind any sysex close; real-time packets too
		if (emit || (c[7] && (c >= ST_REALTIME))) begin
			if (new_cnt == 2'd0) begin
				new0 = pkt;
			end else begin
				new1 = pkt;
			end
			new_cnt = new_cnt + 2'd1;
		end

		// Mark the final packet of this byte
		if (new_cnt == 2'd1) begin
			new0.last_of_run = 1'b1;
		end else if (new_cnt == 2'd2) begin
			new1.last_of_run = 1'b1;
		end
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_status_q <= ST_NONE;
			fh_valid_q   <= 1'b0;
			fh_byte_q    <= 7'd0;
			sh_valid_q   <= 1'b0;
			sh_byte_q    <= 7'd0;
			sx_sent_q    <= 1'b0;
		end else if (in_fire) begin
			run_status_q <= n_status;
			fh_valid_q   <= n_fh_valid;
			fh_byte_q    <= n_fh_byte;
			sh_valid_q   <= n_sh_valid;
			sh_byte_q    <= n_sh_byte;
			sx_sent_q    <= n_sx_sent;
		end
	end

	// Result register count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (in_fire) begin
			cnt_q <= new_cnt;
		end else if (out_fire) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (in_fire) begin
			pkt0_q <= new0;
			pkt1_q <= new1;
		end else if (out_fire) begin
			pkt0_q <= pkt1_q;
		end
	end

	// Output drive
	assign evt_out.valid       = (cnt_q != 2'd0);
	assign evt_out.code_index  = pkt0_q.code_index;
	assign evt_out.msg_byte0   = pkt0_q.msg_byte0;
	assign evt_out.msg_byte1   = pkt0_q.msg_byte1;
	assign evt_out.msg_byte2   = pkt0_q.msg_byte2;
	assign evt_out.last_of_run = pkt0_q.last_of_run;

endmodule
